/* design/mafe_pkg.sv */
// Shared types, constants and the hex digit function of the Modbus ASCII frame encoder.
package mafe_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_CR    = 7'h0D;
  localparam logic [6:0] CHAR_LF    = 7'h0A;

  // One classified byte on its way from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] lrc;
  } entry_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_status_t;

  typedef enum logic [2:0] {
    STEP_COLON,
    STEP_HI,
    STEP_LO,
    STEP_LRC_HI,
    STEP_LRC_LO,
    STEP_CR,
    STEP_LF
  } step_e;

  function automatic logic [6:0] hex_char(input logic [3:0] nibble);
    logic [6:0] wide;
    wide = {3'b000, nibble};
    if (nibble < 4'd10) begin
      hex_char = 7'h30 + wide;
    end else begin
      hex_char = 7'h37 + wide;
    end
  endfunction

endpackage

/* design/mafe_front.sv */
// Front end: accepts words, tracks frame position and running sum, forms LRC entries.
module mafe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_frame_i,
  input  mafe_pkg::fifo_status_t fifo_status_i,
  output logic                  push_o,
  output mafe_pkg::entry_t      entry_o
);

  logic [7:0] sum_q, sum_d;
  logic       inside_q, inside_d;
  logic [7:0] new_sum;

  assign in_ready_o = ~fifo_status_i.full;
  assign push_o     = in_valid_i & in_ready_o;

  // A new frame starts its sum from zero.
  assign new_sum = (inside_q ? sum_q : 8'h00) + data_byte_i;

  always_comb begin
    entry_o.data  = data_byte_i;
    entry_o.first = ~inside_q;
    entry_o.last  = end_of_frame_i;
    entry_o.lrc   = (new_sum ^ 8'hFF) + 8'h01;
  end

  always_comb begin
    sum_d    = sum_q;
    inside_d = inside_q;
    if (push_o) begin
      if (end_of_frame_i) begin
        sum_d    = 8'h00;
        inside_d = 1'b0;
      end else begin
        sum_d    = new_sum;
        inside_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= 8'h00;
      inside_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      inside_q <= inside_d;
    end
  end

endmodule

/* design/mafe_fifo.sv */
// Short queue of classified entries between the front and back ends.
module mafe_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mafe_pkg::entry_t       push_entry_i,
  input  logic                   pop_i,
  output mafe_pkg::entry_t       head_o,
  output mafe_pkg::fifo_status_t status_o
);

  mafe_pkg::entry_t                  store_q [mafe_pkg::FIFO_DEPTH];
  logic [mafe_pkg::FIFO_AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mafe_pkg::FIFO_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mafe_pkg::FIFO_CW-1:0]      count_q, count_d;
  logic                              do_pop;

  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == mafe_pkg::FIFO_CW'(mafe_pkg::FIFO_DEPTH));
  assign head_o         = store_q[rd_ptr_q];
  assign do_pop         = pop_i & ~status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q + (push_i ? mafe_pkg::FIFO_AW'(1) : '0);
    rd_ptr_d = rd_ptr_q + (do_pop ? mafe_pkg::FIFO_AW'(1) : '0);
    count_d  = count_q + (push_i ? mafe_pkg::FIFO_CW'(1) : '0)
                       - (do_pop ? mafe_pkg::FIFO_CW'(1) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* design/mafe_back.sv */
// Back end: walks each entry through its characters into the output register.
module mafe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  mafe_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       ascii_char_o,
  output logic             frame_done_o
);

  mafe_pkg::step_e step_q, step_d;
  mafe_pkg::step_e cur_step;
  logic            load;
  logic            last_char;
  logic [6:0]      char_next;
  logic            done_next;
  logic            out_valid_q, out_valid_d;
  logic [6:0]      char_q;
  logic            done_q;

  // Skip the colon for entries that continue a frame.
  assign cur_step = (step_q == mafe_pkg::STEP_COLON && !head_i.first) ?
                    mafe_pkg::STEP_HI : step_q;
  assign load     = head_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o    = load & last_char;

  // Next state.
  always_comb begin
    step_d = step_q;
    if (load) begin
      case (cur_step)
        mafe_pkg::STEP_COLON:  step_d = mafe_pkg::STEP_HI;
        mafe_pkg::STEP_HI:     step_d = mafe_pkg::STEP_LO;
        mafe_pkg::STEP_LO:     step_d = head_i.last ? mafe_pkg::STEP_LRC_HI
                                                    : mafe_pkg::STEP_COLON;
        mafe_pkg::STEP_LRC_HI: step_d = mafe_pkg::STEP_LRC_LO;
        mafe_pkg::STEP_LRC_LO: step_d = mafe_pkg::STEP_CR;
        mafe_pkg::STEP_CR:     step_d = mafe_pkg::STEP_LF;
        mafe_pkg::STEP_LF:     step_d = mafe_pkg::STEP_COLON;
        default:               step_d = mafe_pkg::STEP_COLON;
      endcase
    end
  end

  // Outputs of the current step.
  always_comb begin
    char_next = mafe_pkg::CHAR_COLON;
    done_next = 1'b0;
    last_char = 1'b0;
    case (cur_step)
      mafe_pkg::STEP_COLON:  char_next = mafe_pkg::CHAR_COLON;
      mafe_pkg::STEP_HI:     char_next = mafe_pkg::hex_char(head_i.data[7:4]);
      mafe_pkg::STEP_LO: begin
        char_next = mafe_pkg::hex_char(head_i.data[3:0]);
        last_char = ~head_i.last;
      end
      mafe_pkg::STEP_LRC_HI: char_next = mafe_pkg::hex_char(head_i.lrc[7:4]);
      mafe_pkg::STEP_LRC_LO: char_next = mafe_pkg::hex_char(head_i.lrc[3:0]);
      mafe_pkg::STEP_CR:     char_next = mafe_pkg::CHAR_CR;
      mafe_pkg::STEP_LF: begin
        char_next = mafe_pkg::CHAR_LF;
        done_next = 1'b1;
        last_char = 1'b1;
      end
      default: begin
        char_next = mafe_pkg::CHAR_COLON;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_next;
      done_q <= done_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= mafe_pkg::STEP_COLON;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign frame_done_o = done_q;

endmodule

/* design/modbus_ascii_frame_encoder_top.sv */
// Top level of the Modbus ASCII frame encoder with LRC.
//
// Input channel: one raw frame byte per word (data_byte_i, end_of_frame_i marks
// the last byte), valid/ready. Output channel: one ASCII character per word
// (ascii_char_o), frame_done_o set on the closing line feed, valid/ready.
// A frame comes out as a colon, two upper-case hex digits per byte, two LRC
// digits, CR and LF.
// Throughput: one character per cycle from the output register while the
// receiver is ready. An inner byte gives two characters, the first byte of
// a frame three, the last byte four more, via the queue and output register.
// A four-entry queue between the front end and the character sequencer lets
// the input keep accepting while the output stalls; input ready drops only
// when that queue is full. A stalled receiver holds the current character.
// Reset empties the queue and the output register and starts a new frame.
module modbus_ascii_frame_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] ascii_char_o,
  output logic       frame_done_o
);

  mafe_pkg::entry_t       push_entry;
  mafe_pkg::entry_t       head;
  mafe_pkg::fifo_status_t fifo_status;
  logic                   push;
  logic                   pop;

  mafe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .fifo_status_i  (fifo_status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  mafe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (fifo_status)
  );

  mafe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (~fifo_status.empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .frame_done_o (frame_done_o)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.count <= mafe_pkg::FIFO_CW'(mafe_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == ~fifo_status.full)
    else $error("input ready disagrees with queue state");

  a_done_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (ascii_char_o == mafe_pkg::CHAR_LF))
    else $error("frame done on a character other than line feed");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

/* test/tb_modbus_ascii_frame_encoder_top.sv */
// Testbench for the Modbus ASCII frame encoder: randomized frames checked against a line model.
`timescale 1ns / 100ps

module tb_modbus_ascii_frame_encoder_top;

  localparam int unsigned RANDOM_ITEMS   = 340;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [6:0] ch;
    logic       done;
  } ascii_word_t;

  // Predicts the character stream of each frame and holds the characters still owed.
  class lrc_line_model;
    ascii_word_t pending_chars[$];
    logic [7:0]  frame_sum;
    logic        in_frame;
    int          error_count;

    function new();
      frame_sum   = 8'h00;
      in_frame    = 1'b0;
      error_count = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void push_char(logic [6:0] ch, logic done);
      ascii_word_t w;
      w.ch   = ch;
      w.done = done;
      pending_chars.push_back(w);
    endfunction

    function logic [6:0] digit_of(logic [3:0] nib);
      if (nib < 4'd10) return 7'h30 + {3'b000, nib};
      return 7'h41 + {3'b000, nib} - 7'd10;
    endfunction

    function void push_hex(logic [7:0] b);
      push_char(digit_of(b[7:4]), 1'b0);
      push_char(digit_of(b[3:0]), 1'b0);
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      logic [7:0] lrc;
      if (!in_frame) begin
        push_char(mafe_pkg::CHAR_COLON, 1'b0);
        in_frame  = 1'b1;
        frame_sum = 8'h00;
      end
      push_hex(b);
      frame_sum = frame_sum + b;
      if (eof) begin
        lrc = (frame_sum ^ 8'hFF) + 8'h01;
        push_hex(lrc);
        push_char(mafe_pkg::CHAR_CR, 1'b0);
        push_char(mafe_pkg::CHAR_LF, 1'b1);
        frame_sum = 8'h00;
        in_frame  = 1'b0;
      end
    endfunction

    function void check_char(logic [6:0] ch, logic done);
      ascii_word_t exp_w;
      if (pending_chars.size() == 0) begin
        $error("unexpected word: ascii_char %h frame_done %b", ch, done);
        error_count++;
        return;
      end
      exp_w = pending_chars.pop_front();
      if (ch !== exp_w.ch) begin
        $error("ascii_char: expected %h, actual %h", exp_w.ch, ch);
        error_count++;
      end
      if (done !== exp_w.done) begin
        $error("frame_done: expected %b, actual %b", exp_w.done, done);
        error_count++;
      end
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i    = 8'h00;
  logic       end_of_frame_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [6:0] ascii_char_o;
  logic       frame_done_o;

  lrc_line_model model;
  bit            no_idle  = 1'b0;
  bit            hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  modbus_ascii_frame_encoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ascii_char_o   (ascii_char_o),
    .frame_done_o   (frame_done_o)
  );

  // Enter and leave at a falling edge; valid stays high when the next word follows at once.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    model.note_byte(b, eof);
    @(negedge clk_i);
  endtask

  task automatic take_char();
    int unsigned stall;
    stall = no_idle ? 0 : $urandom_range(0, 13);
    if (hold_req) begin
      hold_req = 1'b0;
      stall    = stall + HOLD_CYCLES;
    end
    if (stall > 0) begin
      out_ready_i <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
    do @(posedge clk_i); while (!out_valid_o);
    model.check_char(ascii_char_o, frame_done_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (model.pending() != 0);
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever take_char();
  end

  // Stop when no word moves on either side for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned items;
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    bit          held;
    bit          paused;
    logic [7:0]  b;

    model  = new();
    items  = 0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-byte frames with LRC 00, 01 and FF
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    // sum wraps to zero
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    // textbook read-holding-registers request
    send_byte(8'h11, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h6B, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b1);
    // nibbles on both sides of the digit/letter boundary
    send_byte(8'h09, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(1, 8);
      else if (pick < 9) len = $urandom_range(9, 20);
      else len = 1;
      if (!held && items >= 120) begin
        held     = 1'b1;
        no_idle  = 1'b0;
        hold_req = 1'b1;
      end
      if (!paused && items >= 240) begin
        paused = 1'b1;
        wait_drained();
      end
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, k == len - 1);
        items++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (model.error_count == 0 && model.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
